/* hw/rtl/rat_alu_pkg.sv */
// Shared constants for the rational accumulator ALU: field widths, operation
// and status codes. No dependencies; every other RTL file imports this package.
`timescale 1ns / 1ps

package rat_alu_pkg;

    localparam int unsigned DEF_VALUE_WIDTH = 32;
    localparam int unsigned OP_W            = 3;
    localparam int unsigned FIELD_W         = 32;
    localparam int unsigned DEN_OUT_W       = 31;
    localparam int unsigned STATUS_W        = 2;
    localparam int unsigned WIDE_W          = 64;
    localparam int unsigned UNIT_W          = WIDE_W + 1;
    localparam int unsigned S_TDATA_W       = 136;
    localparam int unsigned M_TDATA_W       = 72;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_LOAD  = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB   = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL   = 3'd3;
    localparam logic [OP_W-1:0] OP_ADDP  = 3'd4;
    localparam logic [OP_W-1:0] OP_SUBP  = 3'd5;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZDEN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVF  = 2'd2;

    typedef logic [UNIT_W-1:0] unit_word_t;

endpackage

/* hw/rtl/rat_alu_mult.sv */
// Registered 32 x 32 unsigned multiplier shared by all product steps.
// Depends on rat_alu_pkg.
`timescale 1ns / 1ps

module rat_alu_mult (
    input  logic                                  aclk,
    input  logic [rat_alu_pkg::FIELD_W-1:0]       mul_a,
    input  logic [rat_alu_pkg::FIELD_W-1:0]       mul_b,
    output logic [rat_alu_pkg::WIDE_W-1:0]        product
);
    import rat_alu_pkg::*;

    logic [WIDE_W-1:0] product_reg;

    // The product is registered: it is ready in the cycle after the operands are presented.
    always_ff @(posedge aclk) begin
        product_reg <= WIDE_W'(mul_a) * WIDE_W'(mul_b);
    end

    assign product = product_reg;

endmodule

/* hw/rtl/rat_alu_addsub.sv */
// Shared 65-bit adder/subtractor with a no-borrow flag, used by the gcd,
// the restoring divider and the fraction add. Depends on rat_alu_pkg.
`timescale 1ns / 1ps

module rat_alu_addsub (
    input  rat_alu_pkg::unit_word_t opa,
    input  rat_alu_pkg::unit_word_t opb,
    input  logic                    sub,
    output rat_alu_pkg::unit_word_t res,
    output logic                    ge
);
    import rat_alu_pkg::*;

    logic [UNIT_W:0] sum;

    // One extra bit catches the borrow of a subtraction.
    always_comb begin
        if (sub) begin
            sum = {1'b0, opa} - {1'b0, opb};
        end else begin
            sum = {1'b0, opa} + {1'b0, opb};
        end
    end

    assign res = sum[UNIT_W-1:0];
    assign ge  = ~sum[UNIT_W];

endmodule

/* hw/rtl/rational_accumulator_alu.sv */
// Rational accumulator ALU top level: sequencer, working registers and the
// accumulator. Depends on rat_alu_pkg, rat_alu_mult and rat_alu_addsub.
`timescale 1ns / 1ps

// The block holds a signed rational accumulator in lowest terms with a
// positive denominator. Each input beat loads it or combines it with an
// operand fraction (add, subtract, multiply, add or subtract the product of
// operand and factor), and one result beat follows with the new accumulator
// and a status code; on a zero denominator or an out-of-range result the
// accumulator is kept. One item is handled at a time and s_tready is low
// while it is at work. Unused codes and zero denominators need no reduction;
// other items take one or two reductions, which set their time, each a binary
// gcd on 64-bit values (one compare and subtract or one halving per cycle)
// followed by two 64-step restoring divisions, all on the single shared
// adder/subtractor; the products go one per cycle through a registered
// 32 x 32 multiplier.
module rational_accumulator_alu #(
    parameter int unsigned VALUE_WIDTH = rat_alu_pkg::DEF_VALUE_WIDTH  // 8 .. 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // operation[2:0], operand_num[34:3], operand_den[66:35],
    // factor_num[98:67], factor_den[130:99], zero fill above
    input  logic [rat_alu_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // result_num[31:0], result_den[62:32], result_positive[63],
    // status[65:64], zero fill above
    output logic [rat_alu_pkg::M_TDATA_W-1:0]     m_tdata
);
    import rat_alu_pkg::*;

    localparam logic [WIDE_W-1:0] MAXPOS = (WIDE_W'(1) << (VALUE_WIDTH - 1)) - WIDE_W'(1);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_PM0  = 5'd1;
    localparam logic [4:0] S_PM1  = 5'd2;
    localparam logic [4:0] S_PM2  = 5'd3;
    localparam logic [4:0] S_AM0  = 5'd4;
    localparam logic [4:0] S_AM1  = 5'd5;
    localparam logic [4:0] S_AM2  = 5'd6;
    localparam logic [4:0] S_AM3  = 5'd7;
    localparam logic [4:0] S_XM0  = 5'd8;
    localparam logic [4:0] S_XM1  = 5'd9;
    localparam logic [4:0] S_XM2  = 5'd10;
    localparam logic [4:0] S_ADD  = 5'd11;
    localparam logic [4:0] S_ADD2 = 5'd12;
    localparam logic [4:0] S_RED  = 5'd13;
    localparam logic [4:0] S_GCD  = 5'd14;
    localparam logic [4:0] S_DIVM = 5'd15;
    localparam logic [4:0] S_DIVD = 5'd16;
    localparam logic [4:0] S_FIT  = 5'd17;
    localparam logic [4:0] S_OUT  = 5'd18;

    logic [4:0]            state_reg, state_next;
    logic [OP_W-1:0]       op_reg, op_next;
    logic [FIELD_W-1:0]    om_reg, om_next, od_reg, od_next;
    logic [FIELD_W-1:0]    fm_reg, fm_next, fd_reg, fd_next;
    logic                  oneg_reg, oneg_next, fneg_reg, fneg_next;
    logic [FIELD_W-1:0]    a_mag_reg, a_mag_next, a_den_reg, a_den_next;
    logic                  a_neg_reg, a_neg_next;
    logic [FIELD_W-1:0]    acc_mag_reg, acc_mag_next;
    logic [DEN_OUT_W-1:0]  acc_den_reg, acc_den_next;
    logic                  acc_neg_reg, acc_neg_next;
    logic [WIDE_W-1:0]     wm_reg, wm_next, wd_reg, wd_next;
    logic                  wn_reg, wn_next;
    logic [WIDE_W-1:0]     ga_reg, ga_next, gb_reg, gb_next, q_reg, q_next;
    logic [UNIT_W-1:0]     r_reg, r_next;
    logic [5:0]            cnt_reg, cnt_next;
    logic                  final_reg, final_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic                  m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]  m_data_reg, m_data_next;

    logic [FIELD_W-1:0]    mul_a, mul_b;
    logic [WIDE_W-1:0]     product;
    unit_word_t            u_a, u_b, u_res;
    logic                  u_sub, u_ge;

    // Input field views.
    logic [OP_W-1:0]       in_op;
    logic [FIELD_W-1:0]    in_on, in_od, in_fn, in_fd;
    logic [UNIT_W-1:0]     r_sh;
    logic [WIDE_W-1:0]     q_step;
    logic                  fits;
    logic                  s_accept;
    logic                  is_prod;

    assign in_op    = s_tdata[2:0];
    assign in_on    = s_tdata[34:3];
    assign in_od    = s_tdata[66:35];
    assign in_fn    = s_tdata[98:67];
    assign in_fd    = s_tdata[130:99];
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign is_prod  = (in_op == OP_ADDP) || (in_op == OP_SUBP);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    rat_alu_mult u_mult (
        .aclk    (aclk),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .product (product)
    );

    rat_alu_addsub u_addsub (
        .opa (u_a),
        .opb (u_b),
        .sub (u_sub),
        .res (u_res),
        .ge  (u_ge)
    );

    // Multiplier operand selection per sequencer step.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_PM0:   begin mul_a = om_reg;      mul_b = fm_reg; end
            S_PM1:   begin mul_a = od_reg;      mul_b = fd_reg; end
            S_AM0:   begin mul_a = acc_mag_reg; mul_b = a_den_reg; end
            S_AM1:   begin mul_a = a_mag_reg;   mul_b = FIELD_W'(acc_den_reg); end
            S_AM2:   begin mul_a = FIELD_W'(acc_den_reg); mul_b = a_den_reg; end
            S_XM0:   begin mul_a = acc_mag_reg; mul_b = a_mag_reg; end
            S_XM1:   begin mul_a = FIELD_W'(acc_den_reg); mul_b = a_den_reg; end
            default: begin mul_a = '0;          mul_b = '0; end
        endcase
    end

    // Shared adder/subtractor operand selection.
    assign r_sh   = {r_reg[WIDE_W-1:0], q_reg[WIDE_W-1]};
    assign q_step = {q_reg[WIDE_W-2:0], u_ge};

    always_comb begin
        u_a   = '0;
        u_b   = '0;
        u_sub = 1'b1;
        unique case (state_reg) inside
            S_GCD:  begin u_a = {1'b0, ga_reg}; u_b = {1'b0, gb_reg}; end
            S_DIVM, S_DIVD: begin u_a = r_sh; u_b = {1'b0, ga_reg}; end
            S_ADD:  begin
                u_a   = {1'b0, wm_reg};
                u_b   = {1'b0, ga_reg};
                u_sub = (acc_neg_reg != a_neg_reg);
            end
            S_ADD2: begin u_a = {1'b0, ga_reg}; u_b = {1'b0, wm_reg}; end
            default: begin u_a = '0; u_b = '0; end
        endcase
    end

    // Range check of the reduced working fraction.
    always_comb begin
        fits = (wd_reg != '0) && (wd_reg <= MAXPOS) &&
               (wn_reg ? (wm_reg <= MAXPOS + WIDE_W'(1)) : (wm_reg <= MAXPOS));
    end

    // Sequencer and datapath next-state logic.
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        om_next      = om_reg;
        od_next      = od_reg;
        fm_next      = fm_reg;
        fd_next      = fd_reg;
        oneg_next    = oneg_reg;
        fneg_next    = fneg_reg;
        a_mag_next   = a_mag_reg;
        a_den_next   = a_den_reg;
        a_neg_next   = a_neg_reg;
        acc_mag_next = acc_mag_reg;
        acc_den_next = acc_den_reg;
        acc_neg_next = acc_neg_reg;
        wm_next      = wm_reg;
        wd_next      = wd_reg;
        wn_next      = wn_reg;
        ga_next      = ga_reg;
        gb_next      = gb_reg;
        q_next       = q_reg;
        r_next       = r_reg;
        cnt_next     = cnt_reg;
        final_next   = final_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    op_next     = in_op;
                    om_next     = in_on[FIELD_W-1] ? (FIELD_W'(0) - in_on) : in_on;
                    od_next     = in_od[FIELD_W-1] ? (FIELD_W'(0) - in_od) : in_od;
                    fm_next     = in_fn[FIELD_W-1] ? (FIELD_W'(0) - in_fn) : in_fn;
                    fd_next     = in_fd[FIELD_W-1] ? (FIELD_W'(0) - in_fd) : in_fd;
                    oneg_next   = in_on[FIELD_W-1] ^ in_od[FIELD_W-1];
                    fneg_next   = in_fn[FIELD_W-1] ^ in_fd[FIELD_W-1];
                    status_next = ST_OK;
                    if (in_op > OP_SUBP) begin
                        state_next = S_OUT;
                    end else if (in_od == '0 || (is_prod && in_fd == '0)) begin
                        status_next = ST_ZDEN;
                        state_next  = S_OUT;
                    end else if (is_prod) begin
                        final_next = 1'b0;
                        state_next = S_PM0;
                    end else begin
                        // Plain operand: it need not be reduced before combining.
                        final_next = 1'b1;
                        a_mag_next = om_next;
                        a_den_next = od_next;
                        a_neg_next = oneg_next ^ (in_op == OP_SUB);
                        if (in_op == OP_LOAD) begin
                            wm_next    = WIDE_W'(om_next);
                            wd_next    = WIDE_W'(od_next);
                            wn_next    = oneg_next;
                            state_next = S_RED;
                        end else if (in_op == OP_MUL) begin
                            state_next = S_XM0;
                        end else begin
                            state_next = S_AM0;
                        end
                    end
                end
            end
            // Operand times factor.
            S_PM0: state_next = S_PM1;
            S_PM1: begin
                wm_next    = product;
                state_next = S_PM2;
            end
            S_PM2: begin
                wd_next    = product;
                wn_next    = oneg_reg ^ fneg_reg;
                state_next = S_RED;
            end
            // Cross products for a sum: x into wm, y into ga, denominator into wd.
            S_AM0: state_next = S_AM1;
            S_AM1: begin
                wm_next    = product;
                state_next = S_AM2;
            end
            S_AM2: begin
                ga_next    = product;
                state_next = S_AM3;
            end
            S_AM3: begin
                wd_next    = product;
                state_next = S_ADD;
            end
            // Accumulator times operand.
            S_XM0: state_next = S_XM1;
            S_XM1: begin
                wm_next    = product;
                state_next = S_XM2;
            end
            S_XM2: begin
                wd_next    = product;
                wn_next    = acc_neg_reg ^ a_neg_reg;
                state_next = S_RED;
            end
            // Signed magnitude add; a negative difference is redone reversed.
            S_ADD: begin
                if (!u_sub || u_ge) begin
                    wm_next    = u_res[WIDE_W-1:0];
                    wn_next    = acc_neg_reg;
                    state_next = S_RED;
                end else begin
                    state_next = S_ADD2;
                end
            end
            S_ADD2: begin
                wm_next    = u_res[WIDE_W-1:0];
                wn_next    = a_neg_reg;
                state_next = S_RED;
            end
            // Start of a reduction; a zero numerator becomes 0/1 at once.
            S_RED: begin
                if (wm_reg == '0) begin
                    wn_next    = 1'b0;
                    wd_next    = WIDE_W'(1);
                    state_next = S_FIT;
                end else begin
                    ga_next    = wm_reg;
                    gb_next    = wd_reg;
                    state_next = S_GCD;
                end
            end
            // Binary gcd. Common factors of two are stripped from the fraction
            // itself, so the odd gcd left in ga is the divisor.
            S_GCD: begin
                if (!ga_reg[0] && !gb_reg[0]) begin
                    ga_next = ga_reg >> 1;
                    gb_next = gb_reg >> 1;
                    wm_next = wm_reg >> 1;
                    wd_next = wd_reg >> 1;
                end else if (!ga_reg[0]) begin
                    ga_next = ga_reg >> 1;
                end else if (!gb_reg[0]) begin
                    gb_next = gb_reg >> 1;
                end else if (u_res == '0) begin
                    q_next     = wm_reg;
                    r_next     = '0;
                    cnt_next   = '1;
                    state_next = S_DIVM;
                end else if (u_ge) begin
                    ga_next = u_res[WIDE_W:1];
                end else begin
                    ga_next = gb_reg;
                    gb_next = ga_reg;
                end
            end
            // Restoring division of the numerator, then the denominator.
            S_DIVM: begin
                r_next   = u_ge ? u_res : r_sh;
                q_next   = q_step;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == '0) begin
                    wm_next    = q_step;
                    q_next     = wd_reg;
                    r_next     = '0;
                    cnt_next   = '1;
                    state_next = S_DIVD;
                end
            end
            S_DIVD: begin
                r_next   = u_ge ? u_res : r_sh;
                q_next   = q_step;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == '0) begin
                    wd_next    = q_step;
                    state_next = S_FIT;
                end
            end
            // Range check of the product or of the final result.
            S_FIT: begin
                if (!fits) begin
                    status_next = ST_OVF;
                    state_next  = S_OUT;
                end else if (!final_reg) begin
                    a_mag_next = wm_reg[FIELD_W-1:0];
                    a_den_next = wd_reg[FIELD_W-1:0];
                    a_neg_next = wn_reg ^ ((op_reg == OP_SUBP) && (wm_reg != '0));
                    final_next = 1'b1;
                    state_next = S_AM0;
                end else begin
                    acc_mag_next = wm_reg[FIELD_W-1:0];
                    acc_den_next = wd_reg[DEN_OUT_W-1:0];
                    acc_neg_next = wn_reg;
                    state_next   = S_OUT;
                end
            end
            // Hand the accumulator to the output register once it is free.
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'd0, status_reg, ~acc_neg_reg, acc_den_reg,
                                    acc_neg_reg ? (FIELD_W'(0) - acc_mag_reg)
                                                : acc_mag_reg};
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state and accumulator.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            acc_mag_reg <= '0;
            acc_den_reg <= DEN_OUT_W'(1);
            acc_neg_reg <= 1'b0;
            final_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            acc_mag_reg <= acc_mag_next;
            acc_den_reg <= acc_den_next;
            acc_neg_reg <= acc_neg_next;
            final_reg   <= final_next;
        end
    end

    // Working payload registers.
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        om_reg     <= om_next;
        od_reg     <= od_next;
        fm_reg     <= fm_next;
        fd_reg     <= fd_next;
        oneg_reg   <= oneg_next;
        fneg_reg   <= fneg_next;
        a_mag_reg  <= a_mag_next;
        a_den_reg  <= a_den_next;
        a_neg_reg  <= a_neg_next;
        wm_reg     <= wm_next;
        wd_reg     <= wd_next;
        wn_reg     <= wn_next;
        ga_reg     <= ga_next;
        gb_reg     <= gb_next;
        q_reg      <= q_next;
        r_reg      <= r_next;
        cnt_reg    <= cnt_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
    end

    // The accumulator denominator is never zero.
    a_acc_den: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_den_reg != '0)
        else $error("accumulator denominator is zero");

    // An accepted beat blocks the input until its result is loaded into the output register.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("input accepted while busy");

    // Both gcd operands stay nonzero while the gcd runs.
    a_gcd_nz: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_GCD) |-> (ga_reg != '0 && gb_reg != '0))
        else $error("gcd operand reached zero");

    // A zero result always carries denominator one.
    a_zero_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[31:0] == '0) |-> (m_data_reg[62:32] == DEN_OUT_W'(1)))
        else $error("zero result not normalized");

endmodule

/* tb/tb_rational_accumulator_alu.sv */
// Self-checking testbench for the rational accumulator ALU: random and directed
// operations with their expected reduced fractions. Depends on rat_alu_pkg and rational_accumulator_alu.
`timescale 1ns / 1ps

module tb_rational_accumulator_alu;
    import rat_alu_pkg::*;

    localparam int unsigned VW          = DEF_VALUE_WIDTH;
    localparam logic [OP_W-1:0] OP_NOP6 = 3'd6;
    localparam logic [OP_W-1:0] OP_NOP7 = 3'd7;
    localparam int unsigned IDLE_LIMIT  = 20000;
    localparam int unsigned PER_PHASE   = 470;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [31:0]     opnd_num;
        logic [31:0]     opnd_den;
        logic [31:0]     fact_num;
        logic [31:0]     fact_den;
    } alu_cmd_t;

    typedef struct packed {
        logic [31:0]          num;
        logic [DEN_OUT_W-1:0] den;
        logic                 positive;
        logic [STATUS_W-1:0]  status;
    } acc_view_t;

    typedef struct {
        bit          neg;
        bit [63:0]   mag;
        bit [63:0]   den;
    } fraction_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    alu_cmd_t  cmd_q[$];
    acc_view_t acc_expect_q[$];
    alu_cmd_t  cmd_in_flight;
    // The model accumulator starts at the reset value zero over one.
    fraction_t model_acc      = '{1'b0, 64'd0, 64'd1};
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        fail_count     = 0;
    int        result_count   = 0;
    int        status_count[4];
    int        idle_cycles    = 0;

    rational_accumulator_alu i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Fraction arithmetic on 64-bit magnitudes, always returned in lowest terms.
    function automatic fraction_t frac_reduce(input fraction_t f);
        bit [63:0] a;
        bit [63:0] b;
        bit [63:0] r;
        a = f.mag;
        b = f.den;
        while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
        end
        if (a == 0) a = 1;
        f.mag = f.mag / a;
        f.den = f.den / a;
        if (f.mag == 0) begin
            f.neg = 1'b0;
            f.den = 1;
        end
        return f;
    endfunction

    function automatic bit frac_fits(input fraction_t f);
        bit [63:0] maxpos;
        maxpos = (64'd1 << (VW - 1)) - 1;
        if (f.den == 0 || f.den > maxpos) return 1'b0;
        return f.neg ? (f.mag <= maxpos + 1) : (f.mag <= maxpos);
    endfunction

    function automatic fraction_t frac_from_words(input bit [31:0] n, input bit [31:0] d);
        fraction_t f;
        f.mag = n[31] ? (64'h1_0000_0000 - {32'd0, n}) : {32'd0, n};
        f.den = d[31] ? (64'h1_0000_0000 - {32'd0, d}) : {32'd0, d};
        f.neg = n[31] != d[31];
        return frac_reduce(f);
    endfunction

    function automatic fraction_t frac_add(input fraction_t a, input fraction_t b);
        fraction_t r;
        bit [63:0] x;
        bit [63:0] y;
        x = a.mag * b.den;
        y = b.mag * a.den;
        r.den = a.den * b.den;
        if (a.neg == b.neg) begin
            r.mag = x + y;
            r.neg = a.neg;
        end else if (x >= y) begin
            r.mag = x - y;
            r.neg = a.neg;
        end else begin
            r.mag = y - x;
            r.neg = b.neg;
        end
        return frac_reduce(r);
    endfunction

    function automatic fraction_t frac_mul(input fraction_t a, input fraction_t b);
        fraction_t r;
        r.neg = a.neg != b.neg;
        r.mag = a.mag * b.mag;
        r.den = a.den * b.den;
        return frac_reduce(r);
    endfunction

    // Applies one command to the model accumulator and returns the expected beat.
    function automatic acc_view_t accumulate(input alu_cmd_t c);
        acc_view_t           v;
        fraction_t           a;
        fraction_t           res;
        bit                  prod;
        bit                  ok;
        bit [63:0]           neg_mag;
        logic [STATUS_W-1:0] st;
        st  = ST_OK;
        res = model_acc;
        if (c.op <= OP_SUBP) begin
            prod = (c.op == OP_ADDP) || (c.op == OP_SUBP);
            if (c.opnd_den == 0 || (prod && c.fact_den == 0)) begin
                st = ST_ZDEN;
            end else begin
                a  = frac_from_words(c.opnd_num, c.opnd_den);
                ok = 1'b1;
                if (prod) begin
                    a  = frac_mul(a, frac_from_words(c.fact_num, c.fact_den));
                    ok = frac_fits(a);
                    if (c.op == OP_SUBP && a.mag != 0) a.neg = !a.neg;
                end
                if (ok) begin
                    case (c.op)
                        OP_LOAD: res = a;
                        OP_SUB: begin
                            if (a.mag != 0) a.neg = !a.neg;
                            res = frac_add(model_acc, a);
                        end
                        OP_MUL:  res = frac_mul(model_acc, a);
                        default: res = frac_add(model_acc, a);
                    endcase
                    ok = frac_fits(res);
                end
                if (ok) model_acc = res;
                else st = ST_OVF;
            end
        end
        neg_mag    = 64'd0 - model_acc.mag;
        v.num      = model_acc.neg ? neg_mag[31:0] : model_acc.mag[31:0];
        v.den      = model_acc.den[DEN_OUT_W-1:0];
        v.positive = !model_acc.neg;
        v.status   = st;
        return v;
    endfunction

    // Input driver: predicts on every accepted beat, then offers the next one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) acc_expect_q.push_back(accumulate(cmd_in_flight));
            if (!s_tvalid || s_tready) begin
                if (cmd_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cmd_in_flight = cmd_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'd0, cmd_in_flight.fact_den, cmd_in_flight.fact_num,
                                 cmd_in_flight.opnd_den, cmd_in_flight.opnd_num,
                                 cmd_in_flight.op};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random back-pressure and field-by-field comparison.
    always @(posedge aclk) begin
        acc_view_t want;
        acc_view_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (m_tvalid && m_tready) begin
                got.num      = m_tdata[31:0];
                got.den      = m_tdata[62:32];
                got.positive = m_tdata[63];
                got.status   = m_tdata[65:64];
                if (acc_expect_q.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, m_tdata);
                    fail_count++;
                end else begin
                    want = acc_expect_q.pop_front();
                    result_count++;
                    status_count[want.status]++;
                    if (got.num !== want.num) begin
                        $display("%0t: result_num expected %0d got %0d", $time,
                                 $signed(want.num), $signed(got.num));
                        fail_count++;
                    end
                    if (got.den !== want.den) begin
                        $display("%0t: result_den expected %0d got %0d", $time,
                                 want.den, got.den);
                        fail_count++;
                    end
                    if (got.positive !== want.positive) begin
                        $display("%0t: result_positive expected %0d got %0d", $time,
                                 want.positive, got.positive);
                        fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d got %0d", $time,
                                 want.status, got.status);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves a beat.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("[rational_accumulator_alu] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_cmd(input logic [OP_W-1:0] op, input logic [31:0] on,
                           input logic [31:0] od, input logic [31:0] fn,
                           input logic [31:0] fd);
        alu_cmd_t c;
        c.op       = op;
        c.opnd_num = on;
        c.opnd_den = od;
        c.fact_num = fn;
        c.fact_den = fd;
        cmd_q.push_back(c);
    endtask

    // Half are small to keep the accumulator in range; the rest reach up to all 32 bits.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9)) inside
            [0:4]: return $urandom_range(0, 40) - 20;
            [5:6]: return $urandom_range(0, 200000) - 100000;
            7:     return $urandom;
            8: begin
                case ($urandom_range(0, 4))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'd1;
                    3:       return 32'hffff_ffff;
                    default: return 32'd0;
                endcase
            end
            default: return 32'd1 << $urandom_range(0, 31);
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return OP_LOAD;
        if (r < 32) return OP_ADD;
        if (r < 49) return OP_SUB;
        if (r < 65) return OP_MUL;
        if (r < 80) return OP_ADDP;
        if (r < 96) return OP_SUBP;
        return (r < 98) ? OP_NOP6 : OP_NOP7;
    endfunction

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            if (phase == 0) begin
                // Extremes, every operation, zero denominators, overflow and no-ops.
                add_cmd(OP_LOAD, 32'h7fff_ffff, 32'd1, 32'd0, 32'd0);
                add_cmd(OP_ADD,  32'd1, 32'd1, 32'd0, 32'd0);
                add_cmd(OP_LOAD, 32'h8000_0000, 32'd1, 32'd0, 32'd0);
                add_cmd(OP_LOAD, 32'h8000_0000, 32'hffff_ffff, 32'd0, 32'd0);
                add_cmd(OP_LOAD, 32'd6, 32'h8000_0000, 32'd0, 32'd0);
                add_cmd(OP_LOAD, 32'd3, 32'h8000_0000, 32'd0, 32'd0);
                add_cmd(OP_LOAD, 32'd6, 32'hfffffff8, 32'd0, 32'd0);
                add_cmd(OP_ADD,  32'd1, 32'd4, 32'd0, 32'd0);
                add_cmd(OP_SUB,  32'd1, 32'd2, 32'd0, 32'd0);
                add_cmd(OP_SUB,  32'hffff_fffd, 32'd7, 32'd0, 32'd0);
                add_cmd(OP_MUL,  32'd14, 32'hffff_fffd, 32'd0, 32'd0);
                add_cmd(OP_MUL,  32'd0, 32'd5, 32'd0, 32'd0);
                add_cmd(OP_ADD,  32'd5, 32'd0, 32'd0, 32'd0);
                add_cmd(OP_ADDP, 32'd2, 32'd3, 32'd3, 32'd4);
                add_cmd(OP_SUBP, 32'd2, 32'd3, 32'd9, 32'd4);
                add_cmd(OP_ADDP, 32'd2, 32'd3, 32'd9, 32'd0);
                add_cmd(OP_SUBP, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
                add_cmd(OP_ADDP, 32'd1, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff);
                add_cmd(OP_MUL,  32'h7fff_ffff, 32'd1, 32'd0, 32'd0);
                add_cmd(OP_NOP6, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
                add_cmd(OP_NOP7, 32'd0, 32'd0, 32'd0, 32'd0);
                add_cmd(OP_LOAD, 32'h7fff_fffe, 32'h7fff_ffff, 32'd0, 32'd0);
                add_cmd(OP_ADD,  32'd1, 32'h7fff_fffe, 32'd0, 32'd0);
                add_cmd(OP_SUBP, 32'd0, 32'd1, 32'd5, 32'd1);
            end
            for (int i = 0; i < PER_PHASE; i++)
                add_cmd(pick_op(), pick_value(), pick_value(), pick_value(), pick_value());
            do @(posedge aclk);
            while (cmd_q.size() != 0 || s_tvalid || acc_expect_q.size() != 0);
        end
        repeat (50) @(posedge aclk);
        $display("Checked %0d result beats over four handshake-pressure phases:", result_count);
        $display("  %0d ok, %0d zero denominator, %0d overflow; %0d mismatches.",
                 status_count[ST_OK], status_count[ST_ZDEN], status_count[ST_OVF], fail_count);
        if (fail_count == 0 && acc_expect_q.size() == 0) begin
            $display("[rational_accumulator_alu] OK");
        end else begin
            $display("[rational_accumulator_alu] ERROR");
        end
        $finish;
    end

endmodule
